// File: rtl/core/wcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_pkg
// Shared widths, register codes and fixed-point constants of the window
// coefficient generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

    localparam int unsigned LEN_W      = 13;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned BETA_W     = 16;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned WEIGHT_W   = 18;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned MAX_POINTS       = 4096;
    localparam int unsigned BESSEL_TERMS_DEF = 30;

    // register indexes
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_KIND   = 2'd1;
    localparam logic [1:0] REG_BETA   = 2'd2;

    localparam logic [LEN_W-1:0]  LENGTH_RST = 13'd16;
    localparam logic [KIND_W-1:0] KIND_RST   = 3'd0;
    localparam logic [BETA_W-1:0] BETA_RST   = 16'd24576;

    // window kinds
    localparam logic [KIND_W-1:0] KIND_HAMMING = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HANN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_KAISER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BH      = 3'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 18'd131072;

    localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
    localparam logic [31:0] PIHALF_Q30 = 32'd1686629713;

    localparam logic signed [33:0] K_HAM0 = 34'sd579820585;
    localparam logic signed [33:0] K_HAN0 = 34'sd536870912;
    localparam logic signed [33:0] K_BH0  = 34'sd385204879;
    localparam logic [31:0] K_HAM1 = 32'd493921239;
    localparam logic [31:0] K_HANN = 32'd536870912;
    localparam logic [31:0] K_BH1  = 32'd524297395;
    localparam logic [31:0] K_BH2  = 32'd151698245;
    localparam logic [31:0] K_BH3  = 32'd12541305;

    // reciprocals ceil(2^s / d) of the taylor divisors, exact below 2^31
    function automatic logic [31:0] horner_recip(input logic sin_sel, input logic [2:0] step);
        logic [31:0] v;
        begin
            v = 32'd2147483648;
            case ({sin_sel, step})
                4'b0_000: v = 32'd3054198967;
                4'b0_001: v = 32'd2454267027;
                4'b0_010: v = 32'd2290649225;
                4'b0_011: v = 32'd2863311531;
                4'b0_100: v = 32'd2147483648;
                4'b1_000: v = 32'd2498890064;
                4'b1_001: v = 32'd3817748708;
                4'b1_010: v = 32'd3272356036;
                4'b1_011: v = 32'd3435973837;
                4'b1_100: v = 32'd2863311531;
                default:  v = 32'd2147483648;
            endcase
            return v;
        end
    endfunction

    // matching shifts s
    function automatic logic [5:0] horner_shift(input logic sin_sel, input logic [2:0] step);
        logic [5:0] v;
        begin
            v = 6'd32;
            case ({sin_sel, step})
                4'b0_000: v = 6'd38;
                4'b0_001: v = 6'd37;
                4'b0_010: v = 6'd36;
                4'b0_011: v = 6'd35;
                4'b0_100: v = 6'd32;
                4'b1_000: v = 6'd38;
                4'b1_001: v = 6'd38;
                4'b1_010: v = 6'd37;
                4'b1_011: v = 6'd36;
                4'b1_100: v = 6'd34;
                default:  v = 6'd32;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [33:0] win_base(input logic [KIND_W-1:0] kind);
        logic signed [33:0] v;
        begin
            v = K_HAM0;
            if (kind == KIND_HANN)
                v = K_HAN0;
            else if (kind == KIND_BH)
                v = K_BH0;
            return v;
        end
    endfunction

    function automatic logic [31:0] win_coef(input logic [KIND_W-1:0] kind,
                                             input logic [1:0] harm);
        logic [31:0] v;
        begin
            v = K_HAM1;
            if (kind == KIND_HANN)
                v = K_HANN;
            else if (kind == KIND_BH)
            begin
                case (harm)
                    2'd2:    v = K_BH2;
                    2'd3:    v = K_BH3;
                    default: v = K_BH1;
                endcase
            end
            return v;
        end
    endfunction

endpackage

// File: rtl/core/wcg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_if
// Valid/ready channels of the window coefficient generator: sample index
// in, coefficient out.
// ----------------------------------------------------------------------------
interface wcg_sample_if;
    logic                       valid;
    logic                       ready;
    logic [wcg_pkg::IDX_W-1:0]  sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

interface wcg_coef_if;
    logic                          valid;
    logic                          ready;
    logic [wcg_pkg::WEIGHT_W-1:0]  weight;
    logic                          error;

    modport source (output valid, output weight, output error, input ready);
    modport sink   (input valid, input weight, input error, output ready);
endinterface

// File: rtl/core/window_coefficient_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_coefficient_generator
// Returns one coefficient of a symmetric Hamming, Hann, Blackman-Harris or
// Kaiser-Bessel window per sample index, unsigned Q1.17.
//
//  channel  | dir | protocol      | payload
//  ---------+-----+---------------+----------------------------------
//  sample   | in  | valid/ready   | sample_index[11:0]
//  coef     | out | valid/ready   | weight[17:0], error
//  apb      | in  | apb write/rd  | length @0x0, kind @0x4, beta @0x8
//
//  one index at a time through one 32x32 multiplier, one radix-2 divider
//  and a bit-serial square root; ready only while the sequencer is idle
//  work per index: hamming/hann one cosine, blackman-harris three cosines
//  of ten horner steps, each divisor a reciprocal multiply, kaiser a square
//  root and two bessel series of up to BESSEL_TERMS terms each
//  fault cases go from idle straight to the done step, skipping the datapath
//  ready returns in the same cycle that coef valid is loaded
//  a result waiting on coef holds the sequencer in its last step only
//  rst_n clears the sequencer and coef valid and resets the registers
// ----------------------------------------------------------------------------
module window_coefficient_generator #(
    parameter int unsigned BESSEL_TERMS = wcg_pkg::BESSEL_TERMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    wcg_sample_if.sink                        sample,
    wcg_coef_if.source                        coef,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wcg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wcg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wcg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import wcg_pkg::*;

    localparam int unsigned K_W  = $clog2(BESSEL_TERMS + 1);
    localparam int unsigned KK_W = $clog2(BESSEL_TERMS * BESSEL_TERMS + 1);

    localparam logic [6:0] DIV_N_PHASE  = 7'd44;
    localparam logic [6:0] DIV_N_U      = 7'd62;
    localparam logic [6:0] DIV_N_BESSEL = 7'd64;
    localparam logic [6:0] DIV_N_RATIO  = 7'd18;

    typedef enum logic [5:0] {
        S_IDLE, S_DONE, S_MUL, S_DIV,
        S_PHASE, S_W_SETUP, S_W_MUL, S_W_ACC, S_W_FIN,
        S_C_START, S_C_X, S_C_X2, S_H_MUL, S_H_DIV, S_H_NEXT, S_C_END,
        S_K_DD, S_K_U, S_K_SQ0, S_SQRT, S_K_BS, S_K_H, S_K_NUM, S_K_DEN, S_K_RATIO,
        S_B_START, S_B_Y, S_B_MUL, S_B_DIV, S_B_ACC,
        S_MS0, S_MS1, S_MS2, S_MS3, S_MS4
    } state_t;

    // configuration
    logic [LEN_W-1:0]  len_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [BETA_W-1:0] beta_reg;
    logic              cfg_wr;

    // sequencer
    state_t state_reg, mul_ret_reg, div_ret_reg, cos_ret_reg, ms_ret_reg, bes_ret_reg;

    logic [IDX_W-1:0]    d_reg;
    logic [31:0]         p_reg;
    logic [1:0]          harm_reg;
    logic signed [33:0]  acc_reg;
    logic                neg_reg;
    logic [31:0]         ph_reg;
    logic                flip_reg;
    logic [31:0]         x_reg;
    logic [31:0]         x2_reg;
    logic [31:0]         t_reg;
    logic [2:0]          hidx_reg;
    logic                hsin_reg;
    logic signed [31:0]  c_reg;
    logic signed [31:0]  cos_reg;
    logic [31:0]         mul_a_reg, mul_b_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         rem_reg, quo_reg, dvd_reg, dvs_reg;
    logic [6:0]          cnt_reg;
    logic [25:0]         m_reg;
    logic [63:0]         sq_v_reg, sq_r_reg;
    logic [4:0]          sq_i_reg;
    logic [63:0]         ms_a_reg, ms_b_reg, ms_acc_reg;
    logic [63:0]         bh_reg, y_reg, term_reg, sum_reg, num_reg;
    logic [K_W-1:0]      k_reg;
    logic [KK_W-1:0]     kk_reg;
    logic [WEIGHT_W-1:0] wt_reg;
    logic                err_reg;
    logic                coef_valid_reg;
    logic [WEIGHT_W-1:0] coef_weight_reg;
    logic                coef_error_reg;

    // combinational helpers
    logic [IDX_W-1:0]    d_calc;
    logic                in_fault;
    logic [63:0]         div_sh;
    logic                div_ge;
    logic [63:0]         sq_bit, sq_rb;
    logic                sq_ge;
    logic [29:0]         c_f;
    logic                c_flip;
    logic [30:0]         c_g;
    logic [5:0]          h_sh;
    logic [31:0]         h_tn;
    logic signed [31:0]  s_val, ca_val, sa_val, cos_val;
    logic [30:0]         w_r;
    logic signed [33:0]  w_term;
    logic [30:0]         w_cl, w_rnd;
    logic [31:0]         ph_sel;
    logic [63:0]         b_sum_new;
    logic                b_stop;
    logic [18:0]         k_q1;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LENGTH_RST;
            kind_reg <= KIND_RST;
            beta_reg <= BETA_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LENGTH: len_reg  <= pwdata[LEN_W-1:0];
                REG_KIND:   kind_reg <= pwdata[KIND_W-1:0];
                REG_BETA:   beta_reg <= pwdata[BETA_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LENGTH: prdata = APB_DATA_W'(len_reg);
            REG_KIND:   prdata = APB_DATA_W'(kind_reg);
            REG_BETA:   prdata = APB_DATA_W'(beta_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    assign sample.ready = (state_reg == S_IDLE);
    assign coef.valid   = coef_valid_reg;
    assign coef.weight  = coef_weight_reg;
    assign coef.error   = coef_error_reg;

    assign d_calc   = IDX_W'(len_reg - LEN_W'(1));
    assign in_fault = (len_reg < LEN_W'(2)) || (32'(len_reg) > MAX_POINTS)
                   || (kind_reg > KIND_BH) || ({1'b0, sample.sample_index} >= len_reg);

    // restoring divider step
    assign div_sh = {rem_reg[62:0], dvd_reg[63]};
    assign div_ge = (div_sh >= dvs_reg);

    // square root step
    assign sq_bit = 64'd1 << {sq_i_reg, 1'b0};
    assign sq_rb  = sq_r_reg + sq_bit;
    assign sq_ge  = (sq_v_reg >= sq_rb);

    // octant reduction
    assign c_f    = ph_reg[29:0];
    assign c_flip = (c_f > 30'h2000_0000);
    assign c_g    = c_flip ? (Q30_ONE[30:0] - {1'b0, c_f}) : {1'b0, c_f};

    // horner step, quotient by reciprocal
    assign h_sh   = horner_shift(hsin_reg, hidx_reg);
    assign h_tn   = Q30_ONE - 32'(prod_reg >> h_sh);

    always_comb
    begin
        s_val  = $signed(prod_reg[61:30]);
        ca_val = flip_reg ? s_val : c_reg;
        sa_val = flip_reg ? c_reg : s_val;
        case (ph_reg[31:30])
            2'd0:    cos_val = ca_val;
            2'd1:    cos_val = -sa_val;
            2'd2:    cos_val = -ca_val;
            default: cos_val = sa_val;
        endcase
    end

    always_comb
    begin
        case (harm_reg)
            2'd2:    ph_sel = {p_reg[30:0], 1'b0};
            2'd3:    ph_sel = p_reg + {p_reg[30:0], 1'b0};
            default: ph_sel = p_reg;
        endcase
    end

    assign w_r    = prod_reg[60:30];
    assign w_term = neg_reg ? -$signed({3'b000, w_r}) : $signed({3'b000, w_r});

    always_comb
    begin
        if (acc_reg[33])
            w_cl = '0;
        else if (acc_reg > 34'sd1073741824)
            w_cl = Q30_ONE[30:0];
        else
            w_cl = acc_reg[30:0];
        w_rnd = w_cl + 31'd4096;
    end

    assign b_sum_new = sum_reg + quo_reg;
    assign b_stop    = (quo_reg <= (b_sum_new >> 40)) || (k_reg == K_W'(BESSEL_TERMS));
    assign k_q1      = 19'(quo_reg[17:0]) + 19'd1;

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mul_ret_reg    <= S_IDLE;
            div_ret_reg    <= S_IDLE;
            cos_ret_reg    <= S_IDLE;
            ms_ret_reg     <= S_IDLE;
            bes_ret_reg    <= S_IDLE;
            cnt_reg        <= '0;
            hidx_reg       <= '0;
            hsin_reg       <= 1'b0;
            harm_reg       <= '0;
            sq_i_reg       <= '0;
            k_reg          <= '0;
            kk_reg         <= '0;
            coef_valid_reg <= 1'b0;
        end
        else
        begin
            if (coef_valid_reg && coef.ready && (state_reg != S_DONE))
                coef_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        d_reg <= d_calc;
                        if (in_fault)
                        begin
                            wt_reg    <= '0;
                            err_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else if (kind_reg == KIND_KAISER)
                        begin
                            err_reg     <= 1'b0;
                            mul_a_reg   <= 32'(sample.sample_index);
                            mul_b_reg   <= 32'(d_calc - sample.sample_index);
                            mul_ret_reg <= S_K_DD;
                            state_reg   <= S_MUL;
                        end
                        else
                        begin
                            err_reg     <= 1'b0;
                            rem_reg     <= '0;
                            quo_reg     <= '0;
                            dvd_reg     <= {sample.sample_index, 21'd0, d_calc[11:1], 20'd0};
                            dvs_reg     <= 64'(d_calc);
                            cnt_reg     <= DIV_N_PHASE;
                            div_ret_reg <= S_PHASE;
                            state_reg   <= S_DIV;
                        end
                    end
                end

                S_DONE:
                begin
                    if (!coef_valid_reg || coef.ready)
                    begin
                        coef_valid_reg  <= 1'b1;
                        coef_weight_reg <= wt_reg;
                        coef_error_reg  <= err_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= mul_a_reg * mul_b_reg;
                    state_reg <= mul_ret_reg;
                end

                S_DIV:
                begin
                    rem_reg <= div_ge ? (div_sh - dvs_reg) : div_sh;
                    quo_reg <= {quo_reg[62:0], div_ge};
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                        state_reg <= div_ret_reg;
                end

                // cosine-sum windows
                S_PHASE:
                begin
                    p_reg     <= quo_reg[31:0];
                    acc_reg   <= win_base(kind_reg);
                    harm_reg  <= 2'd1;
                    state_reg <= S_W_SETUP;
                end

                S_W_SETUP:
                begin
                    ph_reg      <= ph_sel;
                    cos_ret_reg <= S_W_MUL;
                    state_reg   <= S_C_START;
                end

                S_W_MUL:
                begin
                    neg_reg     <= cos_reg[31];
                    mul_a_reg   <= win_coef(kind_reg, harm_reg);
                    mul_b_reg   <= cos_reg[31] ? 32'(-cos_reg) : 32'(cos_reg);
                    mul_ret_reg <= S_W_ACC;
                    state_reg   <= S_MUL;
                end

                S_W_ACC:
                begin
                    acc_reg <= (harm_reg == 2'd2) ? (acc_reg + w_term) : (acc_reg - w_term);
                    if (kind_reg == KIND_BH && harm_reg != 2'd3)
                    begin
                        harm_reg  <= harm_reg + 2'd1;
                        state_reg <= S_W_SETUP;
                    end
                    else
                        state_reg <= S_W_FIN;
                end

                S_W_FIN:
                begin
                    wt_reg    <= w_rnd[30:13];
                    state_reg <= S_DONE;
                end

                // cosine of one turn fraction
                S_C_START:
                begin
                    flip_reg    <= c_flip;
                    mul_a_reg   <= 32'(c_g);
                    mul_b_reg   <= PIHALF_Q30;
                    mul_ret_reg <= S_C_X;
                    state_reg   <= S_MUL;
                end

                S_C_X:
                begin
                    x_reg       <= prod_reg[61:30];
                    mul_a_reg   <= prod_reg[61:30];
                    mul_b_reg   <= prod_reg[61:30];
                    mul_ret_reg <= S_C_X2;
                    state_reg   <= S_MUL;
                end

                S_C_X2:
                begin
                    x2_reg    <= prod_reg[61:30];
                    t_reg     <= Q30_ONE;
                    hidx_reg  <= '0;
                    hsin_reg  <= 1'b0;
                    state_reg <= S_H_MUL;
                end

                S_H_MUL:
                begin
                    mul_a_reg   <= x2_reg;
                    mul_b_reg   <= t_reg;
                    mul_ret_reg <= S_H_DIV;
                    state_reg   <= S_MUL;
                end

                S_H_DIV:
                begin
                    mul_a_reg   <= prod_reg[61:30];
                    mul_b_reg   <= horner_recip(hsin_reg, hidx_reg);
                    mul_ret_reg <= S_H_NEXT;
                    state_reg   <= S_MUL;
                end

                S_H_NEXT:
                begin
                    if (hidx_reg == 3'd4)
                    begin
                        if (!hsin_reg)
                        begin
                            c_reg     <= $signed(h_tn);
                            t_reg     <= Q30_ONE;
                            hidx_reg  <= '0;
                            hsin_reg  <= 1'b1;
                            state_reg <= S_H_MUL;
                        end
                        else
                        begin
                            mul_a_reg   <= x_reg;
                            mul_b_reg   <= h_tn;
                            mul_ret_reg <= S_C_END;
                            state_reg   <= S_MUL;
                        end
                    end
                    else
                    begin
                        t_reg     <= h_tn;
                        hidx_reg  <= hidx_reg + 3'd1;
                        state_reg <= S_H_MUL;
                    end
                end

                S_C_END:
                begin
                    cos_reg   <= cos_val;
                    state_reg <= cos_ret_reg;
                end

                // kaiser-bessel
                S_K_DD:
                begin
                    m_reg       <= {prod_reg[23:0], 2'b00};
                    mul_a_reg   <= 32'(d_reg);
                    mul_b_reg   <= 32'(d_reg);
                    mul_ret_reg <= S_K_U;
                    state_reg   <= S_MUL;
                end

                S_K_U:
                begin
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    dvd_reg     <= {m_reg, 38'd0};
                    dvs_reg     <= prod_reg;
                    cnt_reg     <= DIV_N_U;
                    div_ret_reg <= S_K_SQ0;
                    state_reg   <= S_DIV;
                end

                S_K_SQ0:
                begin
                    sq_v_reg  <= {quo_reg[39:0], 24'd0};
                    sq_r_reg  <= '0;
                    sq_i_reg  <= 5'd31;
                    state_reg <= S_SQRT;
                end

                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_v_reg <= sq_v_reg - sq_rb;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_i_reg <= sq_i_reg - 5'd1;
                    if (sq_i_reg == 5'd0)
                        state_reg <= S_K_BS;
                end

                S_K_BS:
                begin
                    mul_a_reg   <= 32'(beta_reg);
                    mul_b_reg   <= sq_r_reg[31:0];
                    mul_ret_reg <= S_K_H;
                    state_reg   <= S_MUL;
                end

                S_K_H:
                begin
                    bh_reg      <= {11'd0, prod_reg[63:11]};
                    bes_ret_reg <= S_K_NUM;
                    state_reg   <= S_B_START;
                end

                S_K_NUM:
                begin
                    num_reg     <= sum_reg;
                    bh_reg      <= {29'd0, beta_reg, 19'd0};
                    bes_ret_reg <= S_K_DEN;
                    state_reg   <= S_B_START;
                end

                S_K_DEN:
                begin
                    if (num_reg >= sum_reg)
                    begin
                        wt_reg    <= WEIGHT_ONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rem_reg     <= num_reg;
                        quo_reg     <= '0;
                        dvd_reg     <= '0;
                        dvs_reg     <= sum_reg;
                        cnt_reg     <= DIV_N_RATIO;
                        div_ret_reg <= S_K_RATIO;
                        state_reg   <= S_DIV;
                    end
                end

                S_K_RATIO:
                begin
                    wt_reg    <= k_q1[18:1];
                    state_reg <= S_DONE;
                end

                // bessel i0 series
                S_B_START:
                begin
                    ms_a_reg   <= bh_reg;
                    ms_b_reg   <= bh_reg;
                    ms_ret_reg <= S_B_Y;
                    state_reg  <= S_MS0;
                end

                S_B_Y:
                begin
                    y_reg     <= ms_acc_reg;
                    sum_reg   <= 64'h1_0000_0000;
                    term_reg  <= 64'h1_0000_0000;
                    k_reg     <= K_W'(1);
                    kk_reg    <= KK_W'(1);
                    state_reg <= S_B_MUL;
                end

                S_B_MUL:
                begin
                    ms_a_reg   <= term_reg;
                    ms_b_reg   <= y_reg;
                    ms_ret_reg <= S_B_DIV;
                    state_reg  <= S_MS0;
                end

                S_B_DIV:
                begin
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    dvd_reg     <= ms_acc_reg;
                    dvs_reg     <= 64'(kk_reg);
                    cnt_reg     <= DIV_N_BESSEL;
                    div_ret_reg <= S_B_ACC;
                    state_reg   <= S_DIV;
                end

                S_B_ACC:
                begin
                    term_reg <= quo_reg;
                    sum_reg  <= b_sum_new;
                    if (b_stop)
                        state_reg <= bes_ret_reg;
                    else
                    begin
                        kk_reg    <= kk_reg + KK_W'({k_reg, 1'b1});
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_B_MUL;
                    end
                end

                // 64x64 product shifted down 32, from four partial products
                S_MS0:
                begin
                    mul_a_reg   <= ms_a_reg[63:32];
                    mul_b_reg   <= ms_b_reg[63:32];
                    mul_ret_reg <= S_MS1;
                    state_reg   <= S_MUL;
                end

                S_MS1:
                begin
                    ms_acc_reg  <= {prod_reg[31:0], 32'd0};
                    mul_a_reg   <= ms_a_reg[31:0];
                    mul_b_reg   <= ms_b_reg[63:32];
                    mul_ret_reg <= S_MS2;
                    state_reg   <= S_MUL;
                end

                S_MS2:
                begin
                    ms_acc_reg  <= ms_acc_reg + prod_reg;
                    mul_a_reg   <= ms_a_reg[63:32];
                    mul_b_reg   <= ms_b_reg[31:0];
                    mul_ret_reg <= S_MS3;
                    state_reg   <= S_MUL;
                end

                S_MS3:
                begin
                    ms_acc_reg  <= ms_acc_reg + prod_reg;
                    mul_a_reg   <= ms_a_reg[31:0];
                    mul_b_reg   <= ms_b_reg[31:0];
                    mul_ret_reg <= S_MS4;
                    state_reg   <= S_MUL;
                end

                S_MS4:
                begin
                    ms_acc_reg <= ms_acc_reg + {32'd0, prod_reg[63:32]};
                    state_reg  <= ms_ret_reg;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/wcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_checker
// Port-level checks of the window coefficient generator, bound to the top.
// ----------------------------------------------------------------------------
module wcg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [wcg_pkg::WEIGHT_W-1:0]   out_weight,
    input logic                           out_error
);
    import wcg_pkg::*;

    // coefficient never above one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_weight <= WEIGHT_ONE)
        else $error("weight above one");

    // faulted transfer carries zero weight
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_weight == '0)
        else $error("error with nonzero weight");

    // one index in work at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_weight) && $stable(out_error))
        else $error("stalled result changed");

endmodule

bind window_coefficient_generator wcg_checker u_wcg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (coef.valid),
    .out_ready  (coef.ready),
    .out_weight (coef.weight),
    .out_error  (coef.error)
);

// File: tb/wcg_coef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_coef_checker
// Watches the sample, coefficient and register ports of the window
// coefficient generator, computes each coefficient in fixed point from its
// own copy of the registers and compares every coefficient transfer with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wcg_coef_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    input  logic                               sample_ready,
    input  logic [wcg_pkg::IDX_W-1:0]          sample_index,
    input  logic                               coef_valid,
    input  logic                               coef_ready,
    input  logic [wcg_pkg::WEIGHT_W-1:0]       coef_weight,
    input  logic                               coef_error,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [wcg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wcg_pkg::APB_DATA_W-1:0]     pwdata,
    output int                                 mismatch_count,
    output int                                 outstanding
);
    import wcg_pkg::*;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                error;
    } coef_t;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    coef_t              pending_coefs[$];
    logic [LEN_W-1:0]   cur_length;
    logic [KIND_W-1:0]  cur_kind;
    logic [BETA_W-1:0]  cur_beta;

    function automatic logic [63:0] mulhi32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0, a1, b0, b1;
        begin
            a0 = {32'd0, a[31:0]};
            a1 = a >> 32;
            b0 = {32'd0, b[31:0]};
            b1 = b >> 32;
            return ((a1 * b1) << 32) + a0 * b1 + a1 * b0 + ((a0 * b0) >> 32);
        end
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, bitv;
        begin
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= r + bitv)
                begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                    r = r >> 1;
                bitv = bitv >> 2;
            end
            return r;
        end
    endfunction

    function automatic int horner_div_tb(input logic sin_sel, input int i);
        int cdiv[5];
        int sdiv[5];
        begin
            cdiv = '{90, 56, 30, 12, 2};
            sdiv = '{110, 72, 42, 20, 6};
            return sin_sel ? sdiv[i] : cdiv[i];
        end
    endfunction

    function automatic logic [63:0] taylor_chain(input logic [63:0] x2, input logic sin_sel);
        logic [63:0] t;
        begin
            t = ONE_Q30;
            for (int i = 0; i < 5; i++)
                t = ONE_Q30 - ((x2 * t) >> 30) / 64'(horner_div_tb(sin_sel, i));
            return t;
        end
    endfunction

    function automatic longint cos_of_turn(input logic [31:0] p);
        logic [1:0]  quad;
        logic [63:0] f, g, x, x2;
        logic        flip;
        longint      c, s, ca, sa;
        begin
            quad = p[31:30];
            f = {34'd0, p[29:0]};
            flip = f > (ONE_Q30 >> 1);
            g = flip ? ONE_Q30 - f : f;
            x = (g * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            c = longint'(taylor_chain(x2, 1'b0));
            s = longint'((x * taylor_chain(x2, 1'b1)) >> 30);
            ca = flip ? s : c;
            sa = flip ? c : s;
            case (quad)
                2'd0:    return ca;
                2'd1:    return -sa;
                2'd2:    return -ca;
                default: return sa;
            endcase
        end
    endfunction

    function automatic longint coef_times(input logic [63:0] k, input longint c);
        logic [63:0] mag;
        longint      r;
        begin
            mag = (c < 0) ? 64'(-c) : 64'(c);
            r = longint'((k * mag) >> 30);
            return (c < 0) ? -r : r;
        end
    endfunction

    function automatic logic [63:0] i0_series(input logic [63:0] h);
        logic [63:0] y, sum, term;
        logic        done;
        begin
            y = mulhi32(h, h);
            sum = 64'd1 << 32;
            term = 64'd1 << 32;
            done = 1'b0;
            for (int k = 1; k <= BESSEL_TERMS_DEF; k++)
            begin
                if (!done)
                begin
                    term = mulhi32(term, y) / 64'(k * k);
                    sum = sum + term;
                    if (term <= (sum >> 40))
                        done = 1'b1;
                end
            end
            return sum;
        end
    endfunction

    function automatic logic [63:0] kaiser_coef(input logic [63:0] n, input logic [63:0] d,
                                               input logic [63:0] beta);
        logic [63:0] m, u, s, h, num, den, q, r;
        begin
            m = 4 * n * (d - n);
            u = (m << 36) / (d * d);
            s = int_sqrt(u << 24);
            h = (beta * s) >> 11;
            num = i0_series(h);
            den = i0_series(beta << 19);
            if (num >= den)
                return 64'd1 << 17;
            q = 0;
            r = num;
            for (int i = 0; i < 18; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            return (q + 1) >> 1;
        end
    endfunction

    function automatic logic [63:0] round_q17(input longint w);
        begin
            if (w < 0)
                w = 0;
            if (w > longint'(ONE_Q30))
                w = longint'(ONE_Q30);
            return (64'(w) + 64'd4096) >> 13;
        end
    endfunction

    function automatic coef_t predict_coef(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
                                          input logic [KIND_W-1:0] kind, input logic [BETA_W-1:0] beta);
        coef_t       res;
        logic [63:0] n, d, w;
        logic [31:0] p1, p2, p3;
        begin
            n = 64'(idx);
            res = '0;
            if (len < 2 || len > MAX_POINTS || kind > KIND_BH || n >= 64'(len))
            begin
                res.error = 1'b1;
                return res;
            end
            d = 64'(len) - 1;
            p1 = 32'(((n << 32) + (d >> 1)) / d);
            p2 = p1 * 2;
            p3 = p1 * 3;
            case (kind)
                KIND_HAMMING:
                    w = round_q17(64'sd579820585 - coef_times(64'd493921239, cos_of_turn(p1)));
                KIND_HANN:
                    w = round_q17(64'sd536870912 - coef_times(64'd536870912, cos_of_turn(p1)));
                KIND_KAISER:
                    w = kaiser_coef(n, d, 64'(beta));
                default:
                    w = round_q17(64'sd385204879 - coef_times(64'd524297395, cos_of_turn(p1))
                                  + coef_times(64'd151698245, cos_of_turn(p2))
                                  - coef_times(64'd12541305, cos_of_turn(p3)));
            endcase
            res.weight = w[WEIGHT_W-1:0];
            return res;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coef_t want;
        if (!rst_n)
        begin
            cur_length = LENGTH_RST;
            cur_kind = KIND_RST;
            cur_beta = BETA_RST;
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (coef_valid && coef_ready)
            begin
                if (pending_coefs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected coefficient transfer weight %0d error %0b",
                             $realtime, coef_weight, coef_error);
                end
                else
                begin
                    want = pending_coefs.pop_front();
                    if (coef_weight !== want.weight)
                    begin
                        mismatch_count++;
                        $display("%0t: weight expected %0d actual %0d",
                                 $realtime, want.weight, coef_weight);
                    end
                    if (coef_error !== want.error)
                    begin
                        mismatch_count++;
                        $display("%0t: error expected %0b actual %0b",
                                 $realtime, want.error, coef_error);
                    end
                end
            end
            if (sample_valid && sample_ready)
                pending_coefs.push_back(predict_coef(sample_index, cur_length, cur_kind, cur_beta));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_LENGTH: cur_length = pwdata[LEN_W-1:0];
                    REG_KIND:   cur_kind = pwdata[KIND_W-1:0];
                    REG_BETA:   cur_beta = pwdata[BETA_W-1:0];
                    default:    ;
                endcase
            end
            outstanding = pending_coefs.size();
        end
    end

endmodule

// File: tb/tb_window_coefficient_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_coefficient_generator
// Drives sample indexes and register writes into the window coefficient
// generator with random gaps and backpressure: directed corner cases
// first, then random phases over lengths, kinds and beta values.
// ----------------------------------------------------------------------------
module tb_window_coefficient_generator;
    import wcg_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   gaps_on;
    int                     mismatch_count;
    int                     outstanding;
    logic [LEN_W-1:0]       phase_len;

    wcg_sample_if sample_ch();
    wcg_coef_if   coef_ch();

    window_coefficient_generator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .coef    (coef_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wcg_coef_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_ch.valid),
        .sample_ready   (sample_ch.ready),
        .sample_index   (sample_ch.sample_index),
        .coef_valid     (coef_ch.valid),
        .coef_ready     (coef_ch.ready),
        .coef_weight    (coef_ch.weight),
        .coef_error     (coef_ch.error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        coef_ch.ready = gaps_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
    end

    task automatic send_index(input logic [IDX_W-1:0] idx);
        if (gaps_on && $urandom_range(0, 99) < 35)
        begin
            sample_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.sample_index = idx;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        sample_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [APB_DATA_W-1:0] value);
        drain();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_window(input logic [LEN_W-1:0] len, input logic [KIND_W-1:0] kind,
                              input logic [BETA_W-1:0] beta);
        write_reg(REG_LENGTH, {$urandom} & ~32'h1FFF | 32'(len));
        write_reg(REG_KIND, {$urandom} & ~32'h7 | 32'(kind));
        write_reg(REG_BETA, {$urandom} & ~32'hFFFF | 32'(beta));
        phase_len = len;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                return LEN_W'($urandom_range(0, 1));
            else if (r < 7)
                return LEN_W'($urandom_range(4097, 8191));
            else if (r < 12)
                return LEN_W'(4096);
            else if (r < 20)
                return LEN_W'($urandom_range(2, 4096));
            return LEN_W'($urandom_range(2, 64));
        end
    endfunction

    initial
    begin
        logic [KIND_W-1:0] kind;
        logic [BETA_W-1:0] beta;
        int                r;
        rst_n = 1'b0;
        gaps_on = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_index = '0;
        phase_len = LENGTH_RST;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: hamming of 16 points
        send_index(12'd0);
        send_index(12'd15);
        send_index(12'd8);
        send_index(12'd16);
        send_index(12'd4095);
        // short and long windows
        set_window(13'd0, KIND_HANN, 16'd0);
        send_index(12'd0);
        set_window(13'd1, KIND_HANN, 16'd0);
        send_index(12'd0);
        set_window(13'd8191, KIND_HAMMING, 16'd0);
        send_index(12'd5);
        set_window(13'd4097, KIND_HAMMING, 16'd0);
        send_index(12'd0);
        // undefined kinds
        for (int k = 4; k < 8; k++)
        begin
            set_window(13'd32, KIND_W'(k), 16'd100);
            send_index(12'd3);
        end
        set_window(13'd2, KIND_HANN, 16'd0);
        send_index(12'd0);
        send_index(12'd1);
        for (int k = 0; k < 4; k++)
        begin
            set_window(13'd4096, KIND_W'(k), (k == KIND_KAISER) ? 16'hFFFF : 16'd24576);
            send_index(12'd0);
            send_index(12'd2048);
            send_index(12'd4095);
        end
        set_window(13'd17, KIND_KAISER, 16'd0);
        send_index(12'd8);

        // random phases
        for (int ph = 0; ph < 16; ph++)
        begin
            gaps_on = !(ph >= 5 && ph <= 7);
            r = $urandom_range(0, 99);
            kind = (r < 10) ? KIND_W'($urandom_range(4, 7)) : KIND_W'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            beta = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : BETA_W'($urandom);
            set_window(pick_length(), kind, beta);
            for (int i = 0; i < 50; i++)
            begin
                if (ph == 9 && i == 25)
                    drain();
                if ($urandom_range(0, 99) < 10 || phase_len < 2)
                    send_index(IDX_W'($urandom));
                else
                    send_index(IDX_W'($urandom_range(0, (phase_len > 4096) ? 4095 : phase_len - 1)));
            end
        end

        sample_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: window_coefficient_generator.f
rtl/core/wcg_pkg.sv
rtl/core/wcg_if.sv
rtl/core/window_coefficient_generator.sv
rtl/core/wcg_checker.sv
tb/wcg_coef_checker.sv
tb/tb_window_coefficient_generator.sv
